@@ src/ole_pkg.sv @@
package ole_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      OP_INSERT_AT    = 3'd0,
      OP_REMOVE_AT    = 3'd1,
      OP_READ_AT      = 3'd2,
      OP_READ_FIRST   = 3'd3,
      OP_READ_LAST    = 3'd4,
      OP_REMOVE_FIRST = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic start_shift;
      logic shift_step;
      logic write_value;
      logic issue_read;
      logic inc_count;
      logic dec_count;
      logic set_full;
      logic set_empty;
      logic set_found;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_insert;
      logic is_remove;
      logic is_read;
      logic full;
      logic empty;
      logic rd_hit;
      logic needs_shift;
      logic last_step;
   } dp_stat_type;

endpackage

@@ src/ordered_list_engine.sv @@
// Ordered list engine: a bounded list of up to DEPTH words with positional insert and removal.
//
// Request channel (req_valid/req_ready): a beat carries req_command, req_position and
// req_value. Commands are insert at position, remove at position, read at position, read
// first, read last and remove first. Insert and remove-at take a position >= count as the end.
// Response channel (rsp_valid/rsp_ready): one beat per request, carrying the word read (zero
// for non-read commands), a found flag, a status (ok, empty on removal, full on insert) and
// the count after the operation.
//
// One request is worked on at a time. Reads and rejected commands pass through an execute
// state and a done state, where the response register is loaded; an insert or removal that
// moves entries adds a shift state, which steps once for every entry shifted through the
// single-port memory, and an insert adds a write state for the new word. A new request is
// taken once the previous result has been placed in the output register.
// If the receiver stalls, a finished result waits in the output register and the next
// request is still worked on; it waits in its final state until the register is freed.
// Synchronous reset empties the list and drops any pending response; the store itself is
// not cleared, as only written entries are ever read.
module ordered_list_engine #(
   parameter int DEPTH      = ole_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ole_pkg::CMD_W-1:0]     req_command,
   input  logic [ole_pkg::POS_W-1:0]     req_position,
   input  logic [ole_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ole_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                          rsp_found,
   output logic [ole_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ole_pkg::COUNT_W-1:0]   rsp_count
);
   import ole_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   ole_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_stat        (dp_stat),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule

@@ src/ole_dp.sv @@
module ole_dp #(
   parameter int DEPTH      = ole_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ole_pkg::dp_cmd_type           dp_cmd,
   output ole_pkg::dp_stat_type          dp_stat,
   input  logic [ole_pkg::CMD_W-1:0]     req_command,
   input  logic [ole_pkg::POS_W-1:0]     req_position,
   input  logic [ole_pkg::VALUE_W-1:0]   req_value,
   output logic [ole_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                          rsp_found,
   output logic [ole_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ole_pkg::COUNT_W-1:0]   rsp_count
);
   import ole_pkg::*;

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int EXT_W     = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CNT_EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [DATA_WIDTH-1:0] entry_mem [DEPTH];

   logic [CMD_W-1:0]      op_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      dst_ff;
   logic                  found_ff;
   status_type            status_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [VALUE_W-1:0]    rsp_read_value_ff;
   logic                  rsp_found_ff;
   status_type            rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [EXT_W-1:0]      value_ext;
   logic [EXT_W-1:0]      rd_ext;
   logic [CNT_EXT_W-1:0]  count_ext;

   logic                  is_insert;
   logic                  is_remove;
   logic                  is_read;
   logic                  full;
   logic                  empty;
   logic                  pos_in_list;
   logic [CNT_W-1:0]      pos_trunc;
   logic [CNT_W-1:0]      last_idx;
   logic [CNT_W-1:0]      ins_pos;
   logic [CNT_W-1:0]      rm_pos;
   logic [CNT_W-1:0]      rd_pos;
   logic                  rd_hit;
   logic                  needs_shift;
   logic                  last_step;

   logic                  rd_en;
   logic [CNT_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [CNT_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [CNT_W-1:0]      dst_in;
   logic [CNT_W-1:0]      count_in;

   assign value_ext = EXT_W'(req_value);
   assign rd_ext    = EXT_W'(rd_data_ff);
   assign count_ext = CNT_EXT_W'(count_ff);

   assign is_insert = (op_ff == OP_INSERT_AT);
   assign is_remove = (op_ff == OP_REMOVE_AT) || (op_ff == OP_REMOVE_FIRST);
   assign is_read   = (op_ff == OP_READ_AT) || (op_ff == OP_READ_FIRST) ||
                      (op_ff == OP_READ_LAST);

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign empty       = (count_ff == '0);
   assign pos_in_list = (CMP_W'(pos_ff) < CMP_W'(count_ff));
   assign pos_trunc   = CNT_W'(pos_ff);
   assign last_idx    = count_ff - CNT_W'(1);

   // A position at or past the end appends on insert and takes the last entry on removal.
   assign ins_pos = pos_in_list ? pos_trunc : count_ff;

   always_comb begin
      if (op_ff == OP_REMOVE_FIRST) begin
         rm_pos = '0;
      end else if (pos_in_list) begin
         rm_pos = pos_trunc;
      end else begin
         rm_pos = last_idx;
      end
   end

   always_comb begin
      rd_hit = 1'b0;
      rd_pos = '0;
      if (op_ff == OP_READ_AT) begin
         rd_hit = pos_in_list;
         rd_pos = pos_trunc;
      end else if (op_ff == OP_READ_FIRST) begin
         rd_hit = !empty;
      end else if (op_ff == OP_READ_LAST) begin
         rd_hit = !empty;
         rd_pos = last_idx;
      end
   end

   always_comb begin
      if (is_insert) begin
         needs_shift = pos_in_list;
         last_step   = ((CNT_W+1)'(dst_ff) == (CNT_W+1)'(ins_pos) + (CNT_W+1)'(1));
      end else begin
         needs_shift = ((CNT_W+1)'(rm_pos) + (CNT_W+1)'(1) < (CNT_W+1)'(count_ff));
         last_step   = ((CNT_W+1)'(dst_ff) + (CNT_W+1)'(2) == (CNT_W+1)'(count_ff));
      end
   end

   always_comb begin
      dp_stat.is_insert   = is_insert;
      dp_stat.is_remove   = is_remove;
      dp_stat.is_read     = is_read;
      dp_stat.full        = full;
      dp_stat.empty       = empty;
      dp_stat.rd_hit      = rd_hit;
      dp_stat.needs_shift = needs_shift;
      dp_stat.last_step   = last_step;
   end

   // The shift is pipelined: each cycle writes the word read in the previous cycle and
   // reads the source of the next destination. Inserts walk down, removals walk up.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = dst_ff;
      wr_data = rd_data_ff;
      dst_in  = dst_ff;
      if (dp_cmd.start_shift) begin
         rd_en = 1'b1;
         if (is_insert) begin
            rd_addr = last_idx;
            dst_in  = count_ff;
         end else begin
            rd_addr = rm_pos + CNT_W'(1);
            dst_in  = rm_pos;
         end
      end else if (dp_cmd.shift_step) begin
         wr_en = 1'b1;
         rd_en = !last_step;
         if (is_insert) begin
            rd_addr = dst_ff - CNT_W'(2);
            dst_in  = dst_ff - CNT_W'(1);
         end else begin
            rd_addr = dst_ff + CNT_W'(2);
            dst_in  = dst_ff + CNT_W'(1);
         end
      end else if (dp_cmd.issue_read) begin
         rd_en   = 1'b1;
         rd_addr = rd_pos;
      end else if (dp_cmd.write_value) begin
         wr_en   = 1'b1;
         wr_addr = ins_pos;
         wr_data = word_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.inc_count) begin
         count_in = count_ff + CNT_W'(1);
      end else if (dp_cmd.dec_count) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= dst_in;
      if (dp_cmd.load_req) begin
         op_ff     <= req_command;
         pos_ff    <= req_position;
         word_ff   <= value_ext[DATA_WIDTH-1:0];
         found_ff  <= 1'b0;
         status_ff <= ST_OK;
      end
      if (dp_cmd.set_full) begin
         status_ff <= ST_FULL;
      end
      if (dp_cmd.set_empty) begin
         status_ff <= ST_EMPTY;
      end
      if (dp_cmd.set_found) begin
         found_ff <= 1'b1;
      end
      if (dp_cmd.load_rsp) begin
         rsp_read_value_ff <= found_ff ? rd_ext[VALUE_W-1:0] : '0;
         rsp_found_ff      <= found_ff;
         rsp_status_ff     <= status_ff;
         rsp_count_ff      <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_inc_not_full : assert property (@(posedge clock) disable iff (reset)
      dp_cmd.inc_count |-> !full)
      else $error("insert into a full list");

   a_dec_not_empty : assert property (@(posedge clock) disable iff (reset)
      dp_cmd.dec_count |-> !empty)
      else $error("removal from an empty list");

endmodule

@@ src/ole_ctrl.sv @@
module ole_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ole_pkg::dp_cmd_type   dp_cmd,
   input  ole_pkg::dp_stat_type  dp_stat
);
   import ole_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_INSWR = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd       = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            if (dp_stat.is_insert) begin
               if (dp_stat.full) begin
                  dp_cmd.set_full = 1'b1;
               end else if (dp_stat.needs_shift) begin
                  dp_cmd.start_shift = 1'b1;
                  state_in           = S_SHIFT;
               end else begin
                  state_in = S_INSWR;
               end
            end else if (dp_stat.is_remove) begin
               if (dp_stat.empty) begin
                  dp_cmd.set_empty = 1'b1;
               end else if (dp_stat.needs_shift) begin
                  dp_cmd.start_shift = 1'b1;
                  state_in           = S_SHIFT;
               end else begin
                  dp_cmd.dec_count = 1'b1;
               end
            end else if (dp_stat.is_read && dp_stat.rd_hit) begin
               dp_cmd.issue_read = 1'b1;
               dp_cmd.set_found  = 1'b1;
            end
         end
         S_SHIFT: begin
            dp_cmd.shift_step = 1'b1;
            if (dp_stat.last_step) begin
               if (dp_stat.is_insert) begin
                  state_in = S_INSWR;
               end else begin
                  dp_cmd.dec_count = 1'b1;
                  state_in         = S_DONE;
               end
            end
         end
         S_INSWR: begin
            dp_cmd.write_value = 1'b1;
            dp_cmd.inc_count   = 1'b1;
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               dp_cmd.load_rsp = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished result not presented");

   a_shift_only_for_list_ops : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (dp_stat.is_insert || dp_stat.is_remove))
      else $error("shift entered for a read command");

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> (state_ff == S_EXEC) && $past(dp_cmd.load_req))
      else $error("accepted beat not started");

endmodule

@@ tb/testbench.sv @@
module testbench;

   import ole_pkg::*;

   localparam int unsigned LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int unsigned HALF_PERIOD  = 4;
   localparam int unsigned RESET_CYCLES = 9;
   // Worst case is one full shift of the list plus the fixed overhead.
   localparam int unsigned TAIL_CYCLES  = LIST_DEPTH + 16;
   localparam int unsigned CYCLE_LIMIT  = 800000;

   // Codes 6 and 7 are not decoded and must leave the list alone.
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   // Idling stages: sender light and receiver heavy, then swapped, then none.
   localparam logic [1:0] STAGE_RX_SLOW = 2'd0;
   localparam logic [1:0] STAGE_TX_SLOW = 2'd1;
   localparam logic [1:0] STAGE_NO_IDLE = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
      logic [1:0]         idle_phase;
      logic               wait_drained;
   } list_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic               found;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_command = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;

   list_item_type       pending_items[$];
   list_result_type     expected_results[$];
   logic [VALUE_W-1:0]  shadow_list[$];
   logic [1:0]          idle_phase = STAGE_RX_SLOW;

   int unsigned         planned_length = 0;
   int unsigned         sent_total = 0;
   int unsigned         accepted_total = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         full_rejects = 0;
   int unsigned         empty_rejects = 0;
   int unsigned         reads_found = 0;
   int unsigned         peak_length = 0;

   ordered_list_engine i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Applies one command to the shadow list and returns the response it should give.
   function automatic list_result_type predict_list_op(input list_item_type op);
      list_result_type res;
      int unsigned     slot;
      res.read_value = '0;
      res.found      = 1'b0;
      res.status     = ST_OK;
      slot           = op.position;
      case (op.command) inside
         OP_INSERT_AT: begin
            if (shadow_list.size() >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               if (slot > shadow_list.size()) slot = shadow_list.size();
               shadow_list.insert(slot, op.value);
            end
         end
         OP_REMOVE_AT, OP_REMOVE_FIRST: begin
            if (shadow_list.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               if (op.command == OP_REMOVE_FIRST) slot = 0;
               else if (slot >= shadow_list.size()) slot = shadow_list.size() - 1;
               shadow_list.delete(slot);
            end
         end
         OP_READ_AT, OP_READ_FIRST, OP_READ_LAST: begin
            if (op.command == OP_READ_FIRST) slot = 0;
            else if (op.command == OP_READ_LAST) slot = shadow_list.size() - 1;
            // On an empty list the last slot wraps to a huge index and misses.
            if (slot < shadow_list.size()) begin
               res.read_value = shadow_list[slot];
               res.found      = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.count = COUNT_W'(shadow_list.size());
      return res;
   endfunction

   function automatic int unsigned idle_pct(input bit sender, input logic [1:0] stage);
      case (stage)
         STAGE_RX_SLOW: return sender ? 31 : 60;
         STAGE_TX_SLOW: return sender ? 60 : 31;
         default:       return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch, cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, want);
   endtask

   task automatic add_item(input logic [CMD_W-1:0] cmd, input int unsigned pos,
                           input logic [VALUE_W-1:0] word);
      list_item_type op;
      op.command      = cmd;
      op.position     = POS_W'(pos);
      op.value        = word;
      op.idle_phase   = STAGE_RX_SLOW;
      op.wait_drained = 1'b0;
      pending_items.push_back(op);
   endtask

   // The planned length follows the list as generated, so that positions and the
   // balance of inserts and removals can be steered towards both full and empty.
   function automatic list_item_type make_random_item(input int unsigned grow_pct,
                                                      input logic [1:0] stage);
      list_item_type op;
      int unsigned   pick;
      op.idle_phase   = stage;
      op.wait_drained = 1'b0;
      pick            = $urandom_range(99);
      case ($urandom_range(3)) inside
         0, 1:    op.position = POS_W'($urandom_range(planned_length));
         2:       op.position = POS_W'(planned_length);
         default: op.position = POS_W'($urandom_range(255));
      endcase
      case ($urandom_range(15))
         0:       op.value = '0;
         1:       op.value = '1;
         default: op.value = $urandom;
      endcase
      if (pick < 3) begin
         op.command = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;
      end else if (pick < 22) begin
         case ($urandom_range(2))
            0:       op.command = OP_READ_AT;
            1:       op.command = OP_READ_FIRST;
            default: op.command = OP_READ_LAST;
         endcase
      end else if ($urandom_range(99) < grow_pct) begin
         op.command = OP_INSERT_AT;
         if (planned_length < LIST_DEPTH) planned_length++;
      end else begin
         op.command = ($urandom_range(1) != 0) ? OP_REMOVE_AT : OP_REMOVE_FIRST;
         if (planned_length > 0) planned_length--;
      end
      return op;
   endfunction

   // Each run is picked at random as filling, draining or a balanced mix.
   task automatic queue_random_items(input int unsigned total, input logic [1:0] stage,
                                     input bit drain_first);
      list_item_type op;
      int unsigned   left;
      int unsigned   run_len;
      int unsigned   grow_pct;
      int unsigned   k;
      left = total;
      while (left > 0) begin
         run_len = $urandom_range(80, 160);
         case ($urandom_range(2))
            0:       grow_pct = 92;
            1:       grow_pct = 8;
            default: grow_pct = 50;
         endcase
         for (k = 0; k < run_len && left > 0; k++) begin
            op = make_random_item(grow_pct, stage);
            if (left == total) op.wait_drained = drain_first;
            pending_items.push_back(op);
            left--;
         end
      end
   endtask

   always @(negedge clock) begin
      list_item_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && sent_total != accepted_total) begin
         // The beat is still waiting for ready; hold it.
      end else if (pending_items.size() > 0
                   && (!pending_items[0].wait_drained || expected_results.size() == 0)
                   && $urandom_range(99) >= idle_pct(1'b1, pending_items[0].idle_phase)) begin
         op = pending_items.pop_front();
         req_valid    <= 1'b1;
         req_command  <= op.command;
         req_position <= op.position;
         req_value    <= op.value;
         idle_phase   <= op.idle_phase;
         sent_total++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct(1'b0, idle_phase));
   end

   always @(posedge clock) begin
      list_item_type   beat;
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response with none outstanding, count", rsp_count, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_count !== want.count)
                  report_mismatch("count", rsp_count, want.count);
            end
         end
         if (req_valid && req_ready) begin
            beat.command      = req_command;
            beat.position     = req_position;
            beat.value        = req_value;
            beat.idle_phase   = idle_phase;
            beat.wait_drained = 1'b0;
            want = predict_list_op(beat);
            expected_results.push_back(want);
            accepted_total++;
            if (want.status == ST_FULL) full_rejects++;
            if (want.status == ST_EMPTY) empty_rejects++;
            if (want.found) reads_found++;
            if (want.count > peak_length) peak_length = want.count;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out with %0d responses outstanding", expected_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // Empty list: reads miss and removals report empty.
      add_item(OP_READ_FIRST, 0, 32'h0000_0000);
      add_item(OP_READ_LAST, 0, 32'h0000_0000);
      add_item(OP_READ_AT, 0, 32'h0000_0000);
      add_item(OP_REMOVE_AT, 0, 32'h0000_0000);
      add_item(OP_REMOVE_FIRST, 255, 32'hFFFF_FFFF);
      // Appends past the end, a front insert and a middle insert, then reads and the two spare codes.
      add_item(OP_INSERT_AT, 255, 32'hFFFF_FFFF);
      add_item(OP_INSERT_AT, 0, 32'h0000_0000);
      add_item(OP_INSERT_AT, 1, 32'hA5A5_5A5A);
      add_item(OP_INSERT_AT, 200, 32'h0000_0001);
      add_item(OP_READ_AT, 0, 32'h0000_0000);
      add_item(OP_READ_AT, 3, 32'h0000_0000);
      add_item(OP_READ_AT, 4, 32'h0000_0000);
      add_item(OP_READ_AT, 255, 32'hFFFF_FFFF);
      add_item(OP_READ_FIRST, 0, 32'h0000_0000);
      add_item(OP_READ_LAST, 0, 32'h0000_0000);
      add_item(CMD_SPARE_6, 0, 32'h0000_0000);
      add_item(CMD_SPARE_7, 255, 32'hFFFF_FFFF);
      // Middle removal, removal past the end, and removal from the front down to empty.
      add_item(OP_REMOVE_AT, 1, 32'h0000_0000);
      add_item(OP_REMOVE_AT, 255, 32'h0000_0000);
      add_item(OP_REMOVE_FIRST, 0, 32'h0000_0000);
      add_item(OP_READ_FIRST, 0, 32'h0000_0000);
      add_item(OP_REMOVE_AT, 0, 32'h0000_0000);
      add_item(OP_READ_LAST, 0, 32'h0000_0000);

      queue_random_items(340, STAGE_RX_SLOW, 1'b1);
      queue_random_items(330, STAGE_TX_SLOW, 1'b1);
      queue_random_items(330, STAGE_NO_IDLE, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_items.size() != 0 || sent_total != accepted_total
             || expected_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests checked, %0d reads hit, peak length %0d of %0d",
               accepted_total, reads_found, peak_length, LIST_DEPTH);
      $display("%0d inserts refused on a full list, %0d removals refused on an empty one",
               full_rejects, empty_rejects);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/ole_pkg.sv
src/ole_dp.sv
src/ole_ctrl.sv
src/ordered_list_engine.sv
tb/testbench.sv
